FILE: sv/plpd_pkg.sv
// Package for the pinned LRU page directory: sizes, codes and the control/status types.
`default_nettype none
package plpd_pkg;

  // Directory geometry
  localparam int SLOTS      = 64;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int AGE_W      = SLOT_W;
  localparam int PAGE_W     = 32;
  localparam int PIN_W      = 16;
  localparam int SAMPLE_W   = 6;
  localparam int CAP_W      = 7;
  localparam int OUT_SLOT_W = 6;
  localparam int CAP_RESET  = 64;

  // Request codes
  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_UNPIN  = 2'd1,
    OP_DROP   = 2'd2,
    OP_IGNORE = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_UNDERFLOW  = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MATCH,
    S_ENCODE,
    S_DECIDE,
    S_SCAN,
    S_RESOLVE,
    S_EVICT,
    S_INSTALL,
    S_DONE
  } state_t;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MATCH,
    CMD_ENCODE,
    CMD_SCAN_START,
    CMD_SCAN,
    CMD_HIT,
    CMD_UNPIN,
    CMD_DROP,
    CMD_EVICT,
    CMD_INSTALL,
    CMD_FULL
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    out_load;
  } plpd_cmd_t;

  typedef struct packed {
    op_t  op;
    logic hit;
    logic at_cap;
    logic scan_last;
    logic vic_found;
    logic free_found;
  } plpd_sts_t;

endpackage
`default_nettype wire

FILE: sv/plpd_ctrl.sv
// Controller state machine for the pinned LRU page directory.
`default_nettype none
module plpd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               out_free,
  input  wire plpd_pkg::plpd_sts_t sts,
  output plpd_pkg::plpd_cmd_t     cmd
);
  import plpd_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd.op       = CMD_NONE;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = CMD_LOAD;
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.op    = CMD_MATCH;
        state_nxt = S_ENCODE;
      end
      S_ENCODE: begin
        cmd.op    = CMD_ENCODE;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        unique case (sts.op)
          OP_GET: begin
            if (sts.hit) begin
              cmd.op = CMD_HIT;
            end else begin
              cmd.op    = CMD_SCAN_START;
              state_nxt = S_SCAN;
            end
          end
          OP_UNPIN: cmd.op = CMD_UNPIN;
          OP_DROP:  cmd.op = CMD_DROP;
          default:  cmd.op = CMD_NONE;
        endcase
      end
      S_SCAN: begin
        cmd.op = CMD_SCAN;
        if (sts.scan_last) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        priority if (!sts.at_cap) begin
          state_nxt = S_INSTALL;
        end else if (sts.vic_found) begin
          cmd.op    = CMD_EVICT;
          state_nxt = S_INSTALL;
        end else begin
          cmd.op    = CMD_FULL;
          state_nxt = S_DONE;
        end
      end
      S_INSTALL: begin
        cmd.op    = sts.free_found ? CMD_INSTALL : CMD_FULL;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/plpd_datapath.sv
// Datapath for the pinned LRU page directory: entry lanes, scan unit and result registers.
`default_nettype none
module plpd_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [1:0]                    in_op,
  input  wire logic [plpd_pkg::PAGE_W-1:0]   in_page_id,
  input  wire logic [plpd_pkg::CAP_W-1:0]    capacity,
  input  wire plpd_pkg::plpd_cmd_t           cmd,
  output plpd_pkg::plpd_sts_t                sts,
  output logic                               res_hit,
  output logic [plpd_pkg::OUT_SLOT_W-1:0]    res_slot,
  output logic                               res_evicted,
  output logic [plpd_pkg::PAGE_W-1:0]        res_evicted_page_id,
  output logic [1:0]                         res_status
);
  import plpd_pkg::*;

  localparam int CMP_W = CAP_W + CNT_W;

  // Entry store, one lane per slot
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [PAGE_W-1:0] page_r [SLOTS];
  logic [PAGE_W-1:0] page_nxt [SLOTS];
  logic [PIN_W-1:0]  pins_r [SLOTS];
  logic [PIN_W-1:0]  pins_nxt [SLOTS];
  logic [AGE_W-1:0]  age_r [SLOTS];
  logic [AGE_W-1:0]  age_nxt [SLOTS];
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;

  // Item being worked on
  op_t               op_r, op_nxt;
  logic [PAGE_W-1:0] id_r, id_nxt;

  // Lookup
  logic [SLOTS-1:0]  match_r, match_nxt;
  logic              hit_r, hit_nxt;
  logic [SLOT_W-1:0] hslot_r, hslot_nxt;

  // Scan unit
  logic [SLOT_W-1:0] scan_r, scan_nxt;
  logic              vic_found_r, vic_found_nxt;
  logic [SLOT_W-1:0] vic_idx_r, vic_idx_nxt;
  logic [AGE_W-1:0]  vic_age_r, vic_age_nxt;
  logic              free_found_r, free_found_nxt;
  logic [SLOT_W-1:0] free_idx_r, free_idx_nxt;

  // Results
  logic              rhit_r, rhit_nxt;
  logic [SLOT_W-1:0] rslot_r, rslot_nxt;
  logic              rev_r, rev_nxt;
  logic [PAGE_W-1:0] revid_r, revid_nxt;
  status_t           rst_r, rst_nxt;

  // Effective capacity clamped to 1..SLOTS
  logic [CMP_W-1:0] cap_ext, cap_eff;
  logic             at_cap;
  logic [SLOT_W-1:0] enc;
  logic [AGE_W-1:0]  a_sel;
  logic [SAMPLE_W-1:0] sample_inc;

  always_comb begin
    cap_ext = CMP_W'(capacity);
    priority if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(SLOTS)) begin
      cap_eff = CMP_W'(SLOTS);
    end else begin
      cap_eff = cap_ext;
    end
    at_cap = CMP_W'(count_r) >= cap_eff;
  end

  // Index of the matching lane (ids are unique among valid entries)
  always_comb begin
    enc = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match_r[i]) begin
        enc = enc | SLOT_W'(i);
      end
    end
  end

  assign sample_inc = sample_r + SAMPLE_W'(1);

  always_comb begin
    valid_nxt      = valid_r;
    page_nxt       = page_r;
    pins_nxt       = pins_r;
    age_nxt        = age_r;
    count_nxt      = count_r;
    sample_nxt     = sample_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    match_nxt      = match_r;
    hit_nxt        = hit_r;
    hslot_nxt      = hslot_r;
    scan_nxt       = scan_r;
    vic_found_nxt  = vic_found_r;
    vic_idx_nxt    = vic_idx_r;
    vic_age_nxt    = vic_age_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    rhit_nxt       = rhit_r;
    rslot_nxt      = rslot_r;
    rev_nxt        = rev_r;
    revid_nxt      = revid_r;
    rst_nxt        = rst_r;
    a_sel          = '0;
    unique case (cmd.op)
      CMD_LOAD: begin
        op_nxt = op_t'(in_op);
        id_nxt = in_page_id;
      end
      CMD_MATCH: begin
        for (int i = 0; i < SLOTS; i++) begin
          match_nxt[i] = valid_r[i] && (page_r[i] == id_r);
        end
      end
      CMD_ENCODE: begin
        hit_nxt   = |match_r;
        hslot_nxt = enc;
        rhit_nxt  = 1'b0;
        rslot_nxt = '0;
        rev_nxt   = 1'b0;
        revid_nxt = '0;
        rst_nxt   = ST_OK;
      end
      CMD_HIT: begin
        rhit_nxt  = 1'b1;
        rslot_nxt = hslot_r;
        if (pins_r[hslot_r] != '1) begin
          pins_nxt[hslot_r] = pins_r[hslot_r] + PIN_W'(1);
        end
        sample_nxt = sample_inc;
        // Promote to most recent on every sample wrap
        if (sample_inc == '0) begin
          a_sel = age_r[hslot_r];
          for (int i = 0; i < SLOTS; i++) begin
            if (valid_r[i] && age_r[i] < a_sel) begin
              age_nxt[i] = age_r[i] + AGE_W'(1);
            end
          end
          age_nxt[hslot_r] = '0;
        end
      end
      CMD_UNPIN: begin
        if (!hit_r) begin
          rst_nxt = ST_NOT_FOUND;
        end else begin
          rslot_nxt = hslot_r;
          if (pins_r[hslot_r] == '0) begin
            rst_nxt = ST_UNDERFLOW;
          end else begin
            pins_nxt[hslot_r] = pins_r[hslot_r] - PIN_W'(1);
          end
        end
      end
      CMD_DROP: begin
        valid_nxt = '0;
        count_nxt = '0;
      end
      CMD_SCAN_START: begin
        scan_nxt       = '0;
        vic_found_nxt  = 1'b0;
        vic_idx_nxt    = '0;
        vic_age_nxt    = '0;
        free_found_nxt = 1'b0;
        free_idx_nxt   = '0;
      end
      CMD_SCAN: begin
        // One slot a cycle: oldest unpinned entry and lowest free slot
        if (valid_r[scan_r]) begin
          if (pins_r[scan_r] == '0 &&
              (!vic_found_r || age_r[scan_r] > vic_age_r)) begin
            vic_found_nxt = 1'b1;
            vic_idx_nxt   = scan_r;
            vic_age_nxt   = age_r[scan_r];
          end
        end else if (!free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = scan_r;
        end
        scan_nxt = scan_r + SLOT_W'(1);
      end
      CMD_EVICT: begin
        rev_nxt   = 1'b1;
        revid_nxt = page_r[vic_idx_r];
        valid_nxt[vic_idx_r] = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (valid_r[i] && SLOT_W'(i) != vic_idx_r && age_r[i] > vic_age_r) begin
            age_nxt[i] = age_r[i] - AGE_W'(1);
          end
        end
        if (count_r != '0) begin
          count_nxt = count_r - CNT_W'(1);
        end
        if (!free_found_r || vic_idx_r < free_idx_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = vic_idx_r;
        end
      end
      CMD_INSTALL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (valid_r[i]) begin
            age_nxt[i] = age_r[i] + AGE_W'(1);
          end
        end
        valid_nxt[free_idx_r] = 1'b1;
        page_nxt[free_idx_r]  = id_r;
        pins_nxt[free_idx_r]  = PIN_W'(1);
        age_nxt[free_idx_r]   = '0;
        count_nxt             = count_r + CNT_W'(1);
        rslot_nxt             = free_idx_r;
      end
      CMD_FULL: begin
        rst_nxt = ST_FULL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      count_r  <= '0;
      sample_r <= '0;
    end else begin
      valid_r  <= valid_nxt;
      count_r  <= count_nxt;
      sample_r <= sample_nxt;
    end
    page_r       <= page_nxt;
    pins_r       <= pins_nxt;
    age_r        <= age_nxt;
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    match_r      <= match_nxt;
    hit_r        <= hit_nxt;
    hslot_r      <= hslot_nxt;
    scan_r       <= scan_nxt;
    vic_found_r  <= vic_found_nxt;
    vic_idx_r    <= vic_idx_nxt;
    vic_age_r    <= vic_age_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    rhit_r       <= rhit_nxt;
    rslot_r      <= rslot_nxt;
    rev_r        <= rev_nxt;
    revid_r      <= revid_nxt;
    rst_r        <= rst_nxt;
  end

  // Status to the controller
  assign sts.op         = op_r;
  assign sts.hit        = hit_r;
  assign sts.at_cap     = at_cap;
  assign sts.scan_last  = scan_r == SLOT_W'(SLOTS - 1);
  assign sts.vic_found  = vic_found_r;
  assign sts.free_found = free_found_r;

  assign res_hit             = rhit_r;
  assign res_slot            = OUT_SLOT_W'(rslot_r);
  assign res_evicted         = rev_r;
  assign res_evicted_page_id = revid_r;
  assign res_status          = rst_r;

endmodule
`default_nettype wire

FILE: sv/pinned_lru_page_directory.sv
// Top level of the pinned LRU page directory: handshakes, capacity register and output register.
// A hit, an unpin, a drop or an ignored code passes through the match, encode and
// decide states before its result is loaded into the output register; a get that
// misses then scans every slot, one slot a cycle, for the oldest unpinned entry and
// the lowest free slot, then evicts a victim if at capacity and installs, skipping the
// install when the pool is full and all pinned. That scan sets the miss rate. A result
// waits until the output register is free, and a new item is accepted only after the
// last result is loaded. The next item is taken while a finished result
// still waits in the output register.
`default_nettype none
module pinned_lru_page_directory (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [plpd_pkg::CAP_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_op,
  input  wire logic [plpd_pkg::PAGE_W-1:0]   in_page_id,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_hit,
  output logic [plpd_pkg::OUT_SLOT_W-1:0]    out_slot,
  output logic                               out_evicted,
  output logic [plpd_pkg::PAGE_W-1:0]        out_evicted_page_id,
  output logic [1:0]                         out_status
);
  import plpd_pkg::*;

  plpd_cmd_t cmd;
  plpd_sts_t sts;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic                  res_hit, res_evicted;
  logic [OUT_SLOT_W-1:0] res_slot;
  logic [PAGE_W-1:0]     res_evicted_page_id;
  logic [1:0]            res_status;
  logic                  hit_r;
  logic [OUT_SLOT_W-1:0] slot_r;
  logic                  ev_r;
  logic [PAGE_W-1:0]     evid_r;
  logic [1:0]            status_r;

  // Capacity register
  assign cfg_ready = 1'b1;
  assign cap_nxt   = cfg_valid ? cfg_data : cap_r;

  // Output register is free when empty or being taken
  assign out_free      = !out_valid_r || out_ready;
  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_W'(CAP_RESET);
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.out_load) begin
      hit_r    <= res_hit;
      slot_r   <= res_slot;
      ev_r     <= res_evicted;
      evid_r   <= res_evicted_page_id;
      status_r <= res_status;
    end
  end

  plpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  plpd_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_op               (in_op),
    .in_page_id          (in_page_id),
    .capacity            (cap_r),
    .cmd                 (cmd),
    .sts                 (sts),
    .res_hit             (res_hit),
    .res_slot            (res_slot),
    .res_evicted         (res_evicted),
    .res_evicted_page_id (res_evicted_page_id),
    .res_status          (res_status)
  );

  assign out_valid           = out_valid_r;
  assign out_hit             = hit_r;
  assign out_slot            = slot_r;
  assign out_evicted         = ev_r;
  assign out_evicted_page_id = evid_r;
  assign out_status          = status_r;

endmodule
`default_nettype wire

FILE: sv/plpd_checker.sv
// Port-level checker for the pinned LRU page directory, bound to the top level.
`default_nettype none
module plpd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_hit,
  input wire logic [5:0]  out_slot,
  input wire logic        out_evicted,
  input wire logic [31:0] out_evicted_page_id,
  input wire logic [1:0]  out_status
);
  import plpd_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_status))
    else $error("stalled result changed");

  // A hit never evicts and is always ok
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted && out_status == ST_OK)
    else $error("hit with eviction or error status");

  // Eviction only on a successful miss
  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit && out_status == ST_OK)
    else $error("eviction on a hit or failed request");

  // No victim id without an eviction
  a_evid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_evicted_page_id == '0)
    else $error("victim id without eviction");

endmodule

bind pinned_lru_page_directory plpd_checker u_plpd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_hit             (out_hit),
  .out_slot            (out_slot),
  .out_evicted         (out_evicted),
  .out_evicted_page_id (out_evicted_page_id),
  .out_status          (out_status)
);
`default_nettype wire
